[rtl/date_to_day_number_weekday_assert.svh]
`ifndef DATE_TO_DAY_NUMBER_WEEKDAY_ASSERT_SVH
`define DATE_TO_DAY_NUMBER_WEEKDAY_ASSERT_SVH

// check a property on every clock edge out of reset
`define DTDN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dtdn assertion failed");

// check a property on every clock edge, reset included
`define DTDN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dtdn assertion failed");

`endif

[rtl/dtdn_pkg.sv]
package dtdn_pkg;

    localparam logic [13:0] C_YEAR_MIN  = 14'd2000;
    localparam logic [13:0] C_YEAR_MAX  = 14'd2099;
    localparam logic [19:0] C_BASE_DAY  = 20'd730119;
    localparam logic [19:0] C_DAYS_YEAR = 20'd365;
    localparam logic [7:0]  C_BASE_WD   = 8'd5;
    localparam logic [4:0]  C_HOUR_MAX  = 5'd23;
    localparam logic [5:0]  C_MIN_MAX   = 6'd59;
    localparam logic [3:0]  C_FEB       = 4'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_WALK,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic        uptime_source;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_item;

    typedef struct packed {
        logic        valid_res;
        logic [4:0]  month_length;
        logic [2:0]  first_weekday;
        logic [2:0]  weekday;
        logic [19:0] day_count;
    } t_res;

    typedef struct packed {
        logic ready;
        logic done;
    } t_core_stat;

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            C_FEB:                                      len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // valid for inputs up to 223
    function automatic logic [2:0] mod7(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd112) r = r - 8'd112;
        if (r >= 8'd56)  r = r - 8'd56;
        if (r >= 8'd28)  r = r - 8'd28;
        if (r >= 8'd14)  r = r - 8'd14;
        if (r >= 8'd7)   r = r - 8'd7;
        return r[2:0];
    endfunction

endpackage

[rtl/dtdn_core.sv]
module dtdn_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  dtdn_pkg::t_item     i_item,
    input  logic                i_out_free,
    output dtdn_pkg::t_core_stat o_stat,
    output dtdn_pkg::t_res      o_res
);
    import dtdn_pkg::*;

    t_state      r_state, n_state;
    t_item       r_item;
    logic        r_ok, n_ok;
    logic        r_leap, n_leap;
    logic [4:0]  r_len, n_len;
    logic [19:0] r_acc, n_acc;
    logic [2:0]  r_wd, n_wd;
    logic [3:0]  r_m, n_m;

    logic [6:0]  w_k;
    logic [4:0]  w_leaps;
    logic        w_leap;
    logic [4:0]  w_len;
    logic        w_pre_ok;
    logic [4:0]  w_walk_len;

    assign w_k      = 7'(r_item.year - C_YEAR_MIN);
    assign w_leaps  = 5'((8'(w_k) + 8'd3) >> 2);
    assign w_leap   = (w_k[1:0] == 2'd0);
    assign w_len    = month_len(r_item.month, w_leap);
    assign w_pre_ok = !r_item.uptime_source
                   && r_item.year >= C_YEAR_MIN && r_item.year <= C_YEAR_MAX
                   && r_item.month >= 4'd1 && r_item.month <= 4'd12
                   && r_item.hour <= C_HOUR_MAX && r_item.minute <= C_MIN_MAX;
    assign w_walk_len = month_len(r_m, r_leap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_item <= i_item;
        end
        r_ok   <= n_ok;
        r_leap <= n_leap;
        r_len  <= n_len;
        r_acc  <= n_acc;
        r_wd   <= n_wd;
        r_m    <= n_m;
    end

    always_comb begin
        n_state     = r_state;
        n_ok        = r_ok;
        n_leap      = r_leap;
        n_len       = r_len;
        n_acc       = r_acc;
        n_wd        = r_wd;
        n_m         = r_m;
        o_stat      = '0;
        o_res       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_stat.ready = 1'b1;
                if (i_start) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                n_ok   = w_pre_ok && r_item.day_of_month >= 5'd1
                      && r_item.day_of_month <= w_len;
                n_leap = w_leap;
                n_len  = w_len;
                n_acc  = C_BASE_DAY + 20'(w_k) * C_DAYS_YEAR + 20'(w_leaps);
                n_wd   = mod7(C_BASE_WD + 8'(w_k) + 8'(w_leaps));
                n_m    = 4'd1;
                n_state = n_ok ? ST_WALK : ST_FIN;
            end
            ST_WALK: begin
                if (r_m == r_item.month) begin
                    n_state = ST_FIN;
                end else begin
                    n_acc = r_acc + 20'(w_walk_len);
                    n_wd  = mod7(8'(r_wd) + 8'(w_walk_len));
                    n_m   = r_m + 4'd1;
                end
            end
            ST_FIN: begin
                if (r_ok) begin
                    o_res.valid_res     = 1'b1;
                    o_res.month_length  = r_len;
                    o_res.first_weekday = r_wd;
                    o_res.weekday       = mod7(8'(r_wd) + 8'(r_item.day_of_month) - 8'd1);
                    o_res.day_count     = r_acc + 20'(r_item.day_of_month) - 20'd1;
                end
                if (i_out_free) begin
                    o_stat.done = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/date_to_day_number_weekday.sv]
// A beat is taken in IDLE; INIT checks it and sets up the year base. A passing
// date walks the months in WALK, one month length per cycle; a failing one skips
// WALK. FIN holds the result until the output register is free; only IDLE takes
// a beat. A new input beat is taken while a finished result waits downstream.
// Reset (synchronous, active low) idles the sequencer and empties the output.
module date_to_day_number_weekday (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // year[13:0], month[17:14], day_of_month[22:18], hour[27:23], minute[33:28]
    input  logic [39:0] s_axis_tdata,
    // uptime_source[0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // month_length[4:0], first_weekday[7:5], weekday[10:8], day_count[30:11]
    output logic [31:0] m_axis_tdata,
    // valid_res[0]
    output logic        m_axis_tuser
);
    import dtdn_pkg::*;

    t_item      w_item;
    t_res       w_res;
    t_core_stat w_stat;
    logic       w_start;
    logic       w_out_free;

    logic        r_m_tvalid;
    logic [31:0] r_m_tdata;
    logic        r_m_tuser;

    assign w_item.uptime_source = s_axis_tuser;
    assign w_item.year          = s_axis_tdata[13:0];
    assign w_item.month         = s_axis_tdata[17:14];
    assign w_item.day_of_month  = s_axis_tdata[22:18];
    assign w_item.hour          = s_axis_tdata[27:23];
    assign w_item.minute        = s_axis_tdata[33:28];

    assign s_axis_tready = w_stat.ready;
    assign w_start       = s_axis_tvalid && w_stat.ready;
    assign w_out_free    = !r_m_tvalid || m_axis_tready;

    dtdn_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_item     (w_item),
        .i_out_free (w_out_free),
        .o_stat     (w_stat),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_stat.done) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_m_tdata <= {1'b0, w_res.day_count, w_res.weekday,
                          w_res.first_weekday, w_res.month_length};
            r_m_tuser <= w_res.valid_res;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

[rtl/dtdn_checker.sv]
`include "date_to_day_number_weekday_assert.svh"

module dtdn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    `DTDN_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `DTDN_ASSERT(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 32'd0)

    `DTDN_ASSERT(a_pass_range, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[4:0] >= 5'd28 && m_axis_tdata[4:0] <= 5'd31 && m_axis_tdata[7:5] != 3'd7 && m_axis_tdata[10:8] != 3'd7)

    `DTDN_ASSERT(a_busy_after_beat, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    `DTDN_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid)

endmodule

bind date_to_day_number_weekday dtdn_checker u_dtdn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[bench/date_to_day_number_weekday_test.sv]
module date_to_day_number_weekday_test;
    import dtdn_pkg::*;

    localparam int PHASE_ITEMS = 360;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT = 3000;

    typedef struct {
        t_item date;
        int    phase;
        bit    drain;
    } t_pending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // year[13:0], month[17:14], day_of_month[22:18], hour[27:23], minute[33:28]
    logic [39:0] s_axis_tdata = '0;
    // uptime_source[0]
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // month_length[4:0], first_weekday[7:5], weekday[10:8], day_count[30:11]
    logic [31:0] m_axis_tdata;
    // valid_res[0]
    logic        m_axis_tuser;

    t_pending    pending_dates[$];
    t_res        expected_results[$];
    t_item       in_flight;
    t_pending    next_date;
    int          cur_phase = 1;
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_valid_seen = 0;
    int          n_invalid_seen = 0;
    int          idle_cycles = 0;

    date_to_day_number_weekday dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned days_in(input int unsigned mo, input bit leap);
        int unsigned len;
        case (mo)
            4, 6, 9, 11: len = 30;
            2:           len = leap ? 29 : 28;
            default:     len = 31;
        endcase
        return len;
    endfunction

    function automatic bit is_leap(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic t_res predict_date(input t_item it);
        t_res        r;
        int unsigned yr, mo, dy, len, prev, first, dnum;
        bit          leap;
        r = '0;
        yr = it.year;
        mo = it.month;
        dy = it.day_of_month;
        if (it.uptime_source || yr < C_YEAR_MIN || yr > C_YEAR_MAX || mo < 1 || mo > 12 ||
            it.hour > C_HOUR_MAX || it.minute > C_MIN_MAX)
            return r;
        leap = is_leap(yr);
        len = days_in(mo, leap);
        if (dy < 1 || dy > len)
            return r;
        prev = yr - 1;
        first = prev * 365 + prev / 4 - prev / 100 + prev / 400;
        for (int unsigned m = 1; m < mo; m++)
            first += days_in(m, leap);
        dnum = first + dy - 1;
        r.valid_res = 1'b1;
        r.month_length = len[4:0];
        r.first_weekday = 3'(first % 7);
        r.weekday = 3'(dnum % 7);
        r.day_count = dnum[19:0];
        return r;
    endfunction

    function automatic t_item make_item(input int src, input int yr, input int mo, input int dy,
                                        input int hr, input int mn);
        t_item it;
        it.uptime_source = 1'(src);
        it.year = 14'(yr);
        it.month = 4'(mo);
        it.day_of_month = 5'(dy);
        it.hour = 5'(hr);
        it.minute = 6'(mn);
        return it;
    endfunction

    function automatic t_item random_good_date();
        int yr, mo;
        yr = $urandom_range(2099, 2000);
        mo = $urandom_range(12, 1);
        return make_item(0, yr, mo, $urandom_range(days_in(mo, is_leap(yr)), 1),
                         $urandom_range(23), $urandom_range(59));
    endfunction

    function automatic t_item random_broken_date();
        t_item it;
        it = random_good_date();
        case ($urandom_range(5))
            0: it.uptime_source = 1'b1;
            1: it.year = $urandom_range(1) ? 14'($urandom_range(1999)) :
                                             14'($urandom_range(16383, 2100));
            2: it.month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
            3: it.day_of_month = $urandom_range(1) ? 5'd0 :
                5'($urandom_range(31, days_in(it.month, is_leap(it.year)) + 1));
            4: it.hour = 5'($urandom_range(31, 24));
            default: it.minute = 6'($urandom_range(63, 60));
        endcase
        return it;
    endfunction

    function automatic t_item random_noise();
        return make_item($urandom_range(1), $urandom_range(16383), $urandom_range(15),
                         $urandom_range(31), $urandom_range(31), $urandom_range(63));
    endfunction

    function automatic int sender_idle_pct(input int ph);
        return (ph == 1) ? 33 : (ph == 2) ? 85 : 0;
    endfunction

    function automatic int receiver_stall_pct(input int ph);
        return (ph == 1) ? 85 : (ph == 2) ? 33 : 0;
    endfunction

    function automatic bit may_send();
        if (pending_dates.size() == 0)
            return 1'b0;
        if (pending_dates[0].drain && (expected_results.size() != 0 || s_axis_tvalid))
            return 1'b0;
        return $urandom_range(99) >= sender_idle_pct(pending_dates[0].phase);
    endfunction

    task automatic queue_date(input t_item it, input int ph, input bit drain);
        t_pending p;
        p.date = it;
        p.phase = ph;
        p.drain = drain;
        pending_dates.push_back(p);
    endtask

    task automatic check_field(input string nm, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
            n_errors++;
        end
    endtask

    // driver: hold the beat until taken, then pick the next date or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_date(in_flight));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (may_send()) begin
                    next_date = pending_dates.pop_front();
                    cur_phase = next_date.phase;
                    in_flight = next_date.date;
                    s_axis_tdata <= {6'b0, in_flight.minute, in_flight.hour,
                                     in_flight.day_of_month, in_flight.month, in_flight.year};
                    s_axis_tuser <= in_flight.uptime_source;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result beat, got tuser %0d tdata %h",
                             $time, m_axis_tuser, m_axis_tdata);
                    n_errors++;
                end else begin
                    t_res want;
                    want = expected_results.pop_front();
                    check_field("valid_res", want.valid_res, m_axis_tuser);
                    check_field("month_length", want.month_length, m_axis_tdata[4:0]);
                    check_field("first_weekday", want.first_weekday, m_axis_tdata[7:5]);
                    check_field("weekday", want.weekday, m_axis_tdata[10:8]);
                    check_field("day_count", want.day_count, m_axis_tdata[30:11]);
                    if (want.valid_res)
                        n_valid_seen++;
                    else
                        n_invalid_seen++;
                end
            end
            m_axis_tready <= $urandom_range(99) >= receiver_stall_pct(cur_phase);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
            $display("date_to_day_number_weekday verification failed");
            $finish;
        end
    end

    initial begin
        int pick;
        // directed corners
        queue_date(make_item(0, 2000, 1, 1, 0, 0), 1, 0);
        queue_date(make_item(0, 2099, 12, 31, 23, 59), 1, 0);
        queue_date(make_item(0, 2000, 2, 29, 12, 30), 1, 0);
        queue_date(make_item(0, 2001, 2, 29, 12, 30), 1, 0);
        queue_date(make_item(0, 2001, 2, 28, 12, 30), 1, 0);
        queue_date(make_item(0, 2096, 2, 29, 7, 7), 1, 0);
        queue_date(make_item(0, 2024, 3, 1, 1, 1), 1, 0);
        queue_date(make_item(0, 2024, 4, 31, 1, 1), 1, 0);
        queue_date(make_item(0, 2024, 4, 30, 1, 1), 1, 0);
        queue_date(make_item(0, 2024, 6, 0, 1, 1), 1, 0);
        queue_date(make_item(1, 2024, 6, 15, 1, 1), 1, 0);
        queue_date(make_item(0, 1999, 12, 31, 23, 59), 1, 0);
        queue_date(make_item(0, 2100, 1, 1, 0, 0), 1, 0);
        queue_date(make_item(0, 0, 1, 1, 0, 0), 1, 0);
        queue_date(make_item(0, 16383, 1, 1, 0, 0), 1, 0);
        queue_date(make_item(0, 2050, 0, 10, 0, 0), 1, 0);
        queue_date(make_item(0, 2050, 13, 10, 0, 0), 1, 0);
        queue_date(make_item(0, 2050, 15, 10, 0, 0), 1, 0);
        queue_date(make_item(0, 2050, 7, 31, 24, 0), 1, 0);
        queue_date(make_item(0, 2050, 7, 31, 31, 0), 1, 0);
        queue_date(make_item(0, 2050, 7, 31, 0, 60), 1, 0);
        queue_date(make_item(0, 2050, 7, 31, 0, 63), 1, 0);
        queue_date(make_item(1, 16383, 15, 31, 31, 63), 1, 0);
        queue_date(make_item(0, 2077, 8, 31, 23, 0), 1, 1);

        for (int ph = 1; ph <= 3; ph++) begin
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    queue_date(random_good_date(), ph, n == 0 || n == PHASE_ITEMS / 2);
                else if (pick < 85)
                    queue_date(random_broken_date(), ph, n == 0 || n == PHASE_ITEMS / 2);
                else
                    queue_date(random_noise(), ph, n == 0 || n == PHASE_ITEMS / 2);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_dates.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d clock readings over three handshake pressure phases;",
                 n_sent);
        $display("checked %0d accepted dates and %0d rejected readings, %0d mismatches.",
                 n_valid_seen, n_invalid_seen, n_errors);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("date_to_day_number_weekday verification clean");
        end else begin
            $display("date_to_day_number_weekday verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/dtdn_pkg.sv
rtl/dtdn_core.sv
rtl/date_to_day_number_weekday.sv
rtl/dtdn_checker.sv
bench/date_to_day_number_weekday_test.sv
